FILE: hw/rtl/iorb_pkg.sv
// Package for the in-order release reorder buffer.
// Holds sizes, command and result codes, and the controller/datapath structs.
// No dependencies.
package iorb_pkg;

    // Storage sizes. TAG_COUNT and QUEUE_DEPTH are powers of two here.
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_COUNT   = 64;
    localparam int FRAME_BITS  = 32;

    // Port field widths.
    localparam int CMD_W       = 2;
    localparam int TAG_IN_W    = 6;
    localparam int FRAME_IN_W  = 32;
    localparam int STATUS_W    = 8;
    localparam int KIND_W      = 2;
    localparam int FRAME_OUT_W = 32;

    // Derived widths.
    localparam int TAG_W   = $clog2(TAG_COUNT);
    localparam int HEAD_W  = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    // Input command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_FULFILL  = 2'd1,
        CMD_FLUSH    = 2'd2,
        CMD_RESET    = 2'd3
    } cmd_code_t;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_FRAME    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd2;

    // Which result the datapath loads into its output register.
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_FRAME,
        EMIT_DONE,
        EMIT_RESET_DONE,
        EMIT_OVERFLOW
    } emit_sel_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      capture;
        logic      push;
        logic      fulfill;
        logic      set_pending;
        logic      clear_pending;
        logic      clear_all;
        logic      pop;
        emit_sel_t emit;
        logic      emit_last;
    } iorb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_code_t cmd;
        logic      full;
        logic      head_ready;
        logic      flush_due;
        logic      flush_pending;
        logic      hold_valid;
        logic      slot_free;
    } iorb_stat_t;

endpackage

FILE: hw/rtl/iorb_datapath.sv
// Datapath of the reorder buffer: tag queue, ready bits, frame memory,
// held release and output register. Depends on iorb_pkg.
module iorb_datapath
    import iorb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [TAG_IN_W-1:0]    s_picture_tag,
    input  logic [FRAME_IN_W-1:0]  s_frame_handle,
    input  logic [STATUS_W-1:0]    s_reset_status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_result_kind,
    output logic [FRAME_OUT_W-1:0] m_released_frame,
    output logic [STATUS_W-1:0]    m_done_status,
    output logic                   m_last,
    input  iorb_cmd_t              ctl,
    output iorb_stat_t             stat
);

    // Captured input item.
    cmd_code_t             cmd_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [STATUS_W-1:0]   status_reg;

    // Queue state.
    logic [TAG_W-1:0]   fifo_reg [QUEUE_DEPTH];
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TAG_COUNT-1:0] tag_ready_reg, tag_ready_next;
    logic               pending_reg, pending_next;

    // Frame memory and its registered read data, which also holds a popped frame.
    logic [FRAME_BITS-1:0] frame_mem [TAG_COUNT];
    logic [FRAME_BITS-1:0] rdata_reg;
    logic                  hold_reg, hold_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [FRAME_OUT_W-1:0] rel_frame_reg;
    logic [STATUS_W-1:0]    done_status_reg;
    logic                   last_reg;

    logic [TAG_W-1:0]    head_tag;
    logic [HEAD_W-1:0]   tail;
    logic [COUNT_W:0]    tail_sum;
    logic                slot_free;

    // Head lookup and tail position (head plus count, wrapped once).
    assign head_tag = fifo_reg[head_reg];
    assign tail_sum = {1'b0, COUNT_W'(head_reg)} + {1'b0, count_reg};
    assign tail     = (tail_sum >= (COUNT_W + 1)'(QUEUE_DEPTH))
                      ? HEAD_W'(tail_sum - (COUNT_W + 1)'(QUEUE_DEPTH))
                      : HEAD_W'(tail_sum);
    assign slot_free = !out_valid_reg || m_ready;

    // Status toward the controller.
    always_comb begin
        stat.cmd           = cmd_reg;
        stat.full          = (count_reg == COUNT_W'(QUEUE_DEPTH));
        stat.head_ready    = (count_reg != '0) && tag_ready_reg[head_tag];
        stat.flush_due     = pending_reg && (count_reg == '0);
        stat.flush_pending = pending_reg;
        stat.hold_valid    = hold_reg;
        stat.slot_free     = slot_free;
    end

    // Capture the input item on acceptance.
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg    <= cmd_code_t'(s_command);
            tag_reg    <= s_picture_tag[TAG_W-1:0];
            frame_reg  <= s_frame_handle[FRAME_BITS-1:0];
            status_reg <= s_reset_status;
        end
    end

    // Queue storage is written only at the tail.
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            fifo_reg[tail] <= tag_reg;
        end
    end

    // Frame memory: written on fulfill, read at the head tag on pop.
    always_ff @(posedge aclk) begin
        if (ctl.fulfill) begin
            frame_mem[tag_reg] <= frame_reg;
        end
        if (ctl.pop) begin
            rdata_reg <= frame_mem[head_tag];
        end
    end

    // Next state of head, count, ready bits, flush flag and held frame.
    always_comb begin
        head_next      = head_reg;
        count_next     = count_reg;
        tag_ready_next = tag_ready_reg;
        pending_next   = pending_reg;
        hold_next      = hold_reg;

        if (ctl.push) begin
            count_next = count_reg + 1'b1;
        end
        if (ctl.fulfill) begin
            tag_ready_next[tag_reg] = 1'b1;
        end
        if (ctl.set_pending) begin
            pending_next = 1'b1;
        end
        if (ctl.clear_pending) begin
            pending_next = 1'b0;
        end
        if (ctl.emit == EMIT_FRAME) begin
            hold_next = 1'b0;
        end
        if (ctl.pop) begin
            tag_ready_next[head_tag] = 1'b0;
            head_next  = (head_reg == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
            hold_next  = 1'b1;
        end
        if (ctl.clear_all) begin
            head_next      = '0;
            count_next     = '0;
            tag_ready_next = '0;
            pending_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            tag_ready_reg <= '0;
            pending_reg   <= 1'b0;
            hold_reg      <= 1'b0;
        end else begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            tag_ready_reg <= tag_ready_next;
            pending_reg   <= pending_next;
            hold_reg      <= hold_next;
        end
    end

    // Output register: loaded by an emit, emptied by a transfer.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (ctl.emit != EMIT_NONE) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit != EMIT_NONE) begin
            last_reg <= ctl.emit_last;
            case (ctl.emit)
                EMIT_FRAME: begin
                    kind_reg        <= KIND_FRAME;
                    rel_frame_reg   <= FRAME_OUT_W'(rdata_reg);
                    done_status_reg <= '0;
                end
                EMIT_DONE: begin
                    kind_reg        <= KIND_DONE;
                    rel_frame_reg   <= '0;
                    done_status_reg <= '0;
                end
                EMIT_RESET_DONE: begin
                    kind_reg        <= KIND_DONE;
                    rel_frame_reg   <= '0;
                    done_status_reg <= status_reg;
                end
                default: begin
                    kind_reg        <= KIND_OVERFLOW;
                    rel_frame_reg   <= '0;
                    done_status_reg <= '0;
                end
            endcase
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_released_frame = rel_frame_reg;
    assign m_done_status    = done_status_reg;
    assign m_last           = last_reg;

`ifndef SYNTHESIS
    // The queue never holds more tags than it has places.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(QUEUE_DEPTH))
        else $error("tag queue count exceeds its depth");

    // A pop only happens on a nonempty queue whose head tag is fulfilled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> (count_reg != '0) && tag_ready_reg[head_tag])
        else $error("pop of an empty queue or an unfulfilled head");

    // A result is loaded only when the output register is free this cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.emit != EMIT_NONE) |-> slot_free)
        else $error("result loaded over an untaken result");

    // A reset command leaves an empty queue and no pending flush.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clear_all |=> (count_reg == '0) && !pending_reg && (tag_ready_reg == '0))
        else $error("reset command left state behind");
`endif

endmodule

FILE: hw/rtl/iorb_ctrl.sv
// Controller of the reorder buffer: sequences command execution and the drain.
// Depends on iorb_pkg.
module iorb_ctrl
    import iorb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  iorb_stat_t stat,
    output iorb_cmd_t  ctl
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ctl        = '0;
        ctl.emit   = EMIT_NONE;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                ctl.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                unique case (stat.cmd)
                    CMD_SCHEDULE: begin
                        // A full queue drops the tag; nothing can drain after it.
                        if (stat.full) begin
                            if (stat.slot_free) begin
                                ctl.emit      = EMIT_OVERFLOW;
                                ctl.emit_last = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end else begin
                            ctl.push   = 1'b1;
                            state_next = ST_CHECK;
                        end
                    end
                    CMD_FULFILL: begin
                        ctl.fulfill = 1'b1;
                        state_next  = ST_CHECK;
                    end
                    CMD_FLUSH: begin
                        ctl.set_pending = 1'b1;
                        state_next      = ST_CHECK;
                    end
                    CMD_RESET: begin
                        // Report a pending flush with the given status, then clear.
                        if (stat.flush_pending) begin
                            if (stat.slot_free) begin
                                ctl.emit      = EMIT_RESET_DONE;
                                ctl.emit_last = 1'b1;
                                ctl.clear_all = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end else begin
                            ctl.clear_all = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_CHECK: begin
                // A held frame is sent once it is known whether more results follow.
                if (stat.hold_valid) begin
                    if (stat.slot_free) begin
                        ctl.emit      = EMIT_FRAME;
                        ctl.emit_last = !(stat.head_ready || stat.flush_due);
                        ctl.pop       = stat.head_ready;
                        if (!(stat.head_ready || stat.flush_due)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (stat.head_ready) begin
                    ctl.pop = 1'b1;
                end else if (stat.flush_due) begin
                    if (stat.slot_free) begin
                        ctl.emit          = EMIT_DONE;
                        ctl.emit_last     = 1'b1;
                        ctl.clear_pending = 1'b1;
                        state_next        = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Input is taken only while no earlier item is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not start execution");

    // A held frame is never overwritten by a pop before it has been sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.pop && stat.hold_valid) |-> (ctl.emit == EMIT_FRAME))
        else $error("pop while a held frame was still unsent");

    // The drain finishes with nothing held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && state_next == ST_IDLE) |=> !stat.hold_valid)
        else $error("drain ended with a frame still held");
`endif

endmodule

FILE: hw/rtl/in_order_release_reorder_buffer.sv
// In-order release reorder buffer: schedule commands queue picture tags in
// output order, fulfill commands bind frame handles to tags, and each fulfill,
// flush or accepted schedule command drains fulfilled tags from the head of the
// queue, releasing their frames in order, then reports a pending flush once the
// queue is empty. A schedule on a full queue reports an overflow instead. A reset
// command reports a pending flush with its status and clears all state. The
// block works on one command at a time. The drain loop reads one frame a cycle
// through the single read port of the frame memory while the output register
// is free; output back-pressure stalls it.
// Depends on iorb_pkg, iorb_ctrl and iorb_datapath.
module in_order_release_reorder_buffer
    import iorb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_command,
    input  logic [TAG_IN_W-1:0]    s_picture_tag,
    input  logic [FRAME_IN_W-1:0]  s_frame_handle,
    input  logic [STATUS_W-1:0]    s_reset_status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_result_kind,
    output logic [FRAME_OUT_W-1:0] m_released_frame,
    output logic [STATUS_W-1:0]    m_done_status,
    output logic                   m_last
);

    iorb_cmd_t  ctl;
    iorb_stat_t stat;

    // Command sequencing.
    iorb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // Queue, tag store and output register.
    iorb_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_command        (s_command),
        .s_picture_tag    (s_picture_tag),
        .s_frame_handle   (s_frame_handle),
        .s_reset_status   (s_reset_status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_released_frame (m_released_frame),
        .m_done_status    (m_done_status),
        .m_last           (m_last),
        .ctl              (ctl),
        .stat             (stat)
    );

endmodule

FILE: bench/in_order_release_reorder_buffer_tb.sv
// Self-checking testbench for the in-order release reorder buffer.
// Drives schedule, fulfill, flush and reset commands and checks every result.
// Depends on iorb_pkg and in_order_release_reorder_buffer.
`timescale 1ns / 100ps

module in_order_release_reorder_buffer_tb;
    import iorb_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 500;
    localparam int SETTLE_CYCLES = 60;

    // One decoder command as it travels on the input channel.
    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [TAG_IN_W-1:0]   tag;
        logic [FRAME_IN_W-1:0] frame;
        logic [STATUS_W-1:0]   status;
    } decoder_cmd_t;

    // One result as it should appear on the output channel.
    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [FRAME_OUT_W-1:0] frame;
        logic [STATUS_W-1:0]    status;
        logic                   last;
    } release_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [CMD_W-1:0]       s_command = CMD_SCHEDULE;
    logic [TAG_IN_W-1:0]    s_picture_tag = '0;
    logic [FRAME_IN_W-1:0]  s_frame_handle = '0;
    logic [STATUS_W-1:0]    s_reset_status = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [KIND_W-1:0]      m_result_kind;
    logic [FRAME_OUT_W-1:0] m_released_frame;
    logic [STATUS_W-1:0]    m_done_status;
    logic                   m_last;

    in_order_release_reorder_buffer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_picture_tag    (s_picture_tag),
        .s_frame_handle   (s_frame_handle),
        .s_reset_status   (s_reset_status),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_released_frame (m_released_frame),
        .m_done_status    (m_done_status),
        .m_last           (m_last)
    );

    // Stimulus and scoreboard storage.
    decoder_cmd_t commands_to_send[$];
    release_t     pending_releases[$];
    int           commands_made = 0;
    int           in_offers = 0;
    int           in_accepts = 0;
    int           mismatch_count = 0;
    int           results_seen = 0;
    int           kind_seen[3] = '{0, 0, 0};
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_requests = 0;
    int           stuck_cycles = 0;

    // Shadow copy of the buffer state used for prediction.
    logic [TAG_W-1:0]       tag_order[QUEUE_DEPTH];
    logic [HEAD_W-1:0]      head_idx = '0;
    logic [COUNT_W-1:0]     fill_count = '0;
    bit                     tag_bound[TAG_COUNT];
    logic [FRAME_OUT_W-1:0] bound_frame[TAG_COUNT];
    bit                     flush_armed = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    function automatic void push_result(logic [KIND_W-1:0] kind,
                                        logic [FRAME_OUT_W-1:0] frame,
                                        logic [STATUS_W-1:0] status);
        release_t r;
        r.kind   = kind;
        r.frame  = frame;
        r.status = status;
        r.last   = 1'b0;
        pending_releases.push_back(r);
    endfunction

    // Release every fulfilled tag at the head, then finish a waiting flush.
    function automatic void drain_fulfilled();
        while (fill_count != 0 && tag_bound[tag_order[head_idx]]) begin
            push_result(KIND_FRAME, bound_frame[tag_order[head_idx]], '0);
            tag_bound[tag_order[head_idx]] = 1'b0;
            head_idx = head_idx + 1'b1;
            fill_count = fill_count - 1'b1;
        end
        if (flush_armed && fill_count == 0) begin
            push_result(KIND_DONE, '0, '0);
            flush_armed = 1'b0;
        end
    endfunction

    // Update the shadow state for one accepted command and queue its results.
    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [TAG_IN_W-1:0] tag_in,
                                          logic [FRAME_IN_W-1:0] frame_in,
                                          logic [STATUS_W-1:0] status);
        int               prior_size;
        logic [TAG_W-1:0] tag;
        logic [HEAD_W-1:0] slot;
        prior_size = pending_releases.size();
        tag = tag_in[TAG_W-1:0];
        case (cmd)
            CMD_SCHEDULE: begin
                if (fill_count >= QUEUE_DEPTH) begin
                    push_result(KIND_OVERFLOW, '0, '0);
                end else begin
                    slot = head_idx + fill_count[HEAD_W-1:0];
                    tag_order[slot] = tag;
                    fill_count = fill_count + 1'b1;
                end
                drain_fulfilled();
            end
            CMD_FULFILL: begin
                tag_bound[tag] = 1'b1;
                bound_frame[tag] = FRAME_OUT_W'(frame_in[FRAME_BITS-1:0]);
                drain_fulfilled();
            end
            CMD_FLUSH: begin
                flush_armed = 1'b1;
                drain_fulfilled();
            end
            default: begin
                if (flush_armed) begin
                    push_result(KIND_DONE, '0, status);
                    flush_armed = 1'b0;
                end
                head_idx = '0;
                fill_count = '0;
                for (int i = 0; i < TAG_COUNT; i++) tag_bound[i] = 1'b0;
            end
        endcase
        if (pending_releases.size() > prior_size)
            pending_releases[pending_releases.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 60)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
        end
    endfunction

    // Driver: offers queued commands at the falling edge, holding each until its transfer.
    always @(negedge aclk) begin : drive_commands
        decoder_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_accepts == in_offers) begin
            if (commands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = commands_to_send.pop_front();
                s_command      <= nxt.cmd;
                s_picture_tag  <= nxt.tag;
                s_frame_handle <= nxt.frame;
                s_reset_status <= nxt.status;
                s_valid        <= 1'b1;
                in_offers++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge aclk) begin : drive_ready
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on each input transfer, then compare each output transfer.
    always @(posedge aclk) begin : check_results
        release_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                apply_command(s_command, s_picture_tag, s_frame_handle, s_reset_status);
                in_accepts++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_result_kind < 3) kind_seen[m_result_kind]++;
                if (pending_releases.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 60)
                        $display("%0t: unexpected result, expected none, actual kind %0d",
                                 $time, m_result_kind);
                end else begin
                    want = pending_releases.pop_front();
                    check_field("result_kind", 32'(want.kind), 32'(m_result_kind));
                    check_field("released_frame", want.frame, m_released_frame);
                    check_field("done_status", 32'(want.status), 32'(m_done_status));
                    check_field("last", 32'(want.last), 32'(m_last));
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, pending_releases.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [TAG_IN_W-1:0] tag,
                           input logic [FRAME_IN_W-1:0] frame,
                           input logic [STATUS_W-1:0] status);
        decoder_cmd_t c;
        c.cmd    = cmd;
        c.tag    = tag;
        c.frame  = frame;
        c.status = status;
        commands_to_send.push_back(c);
        commands_made++;
    endtask

    // One decode episode: schedule a set of tags, fulfill them out of order,
    // with stray commands mixed in, and close with a flush, a reset, or neither.
    task automatic add_episode(input bit overfill);
        logic [TAG_W-1:0] order_tags[$];
        logic [TAG_W-1:0] open_tags[$];
        bit               used[TAG_COUNT];
        logic [TAG_W-1:0] t;
        int               n, i, sched, roll, idx, steps, abort_at;
        n = overfill ? QUEUE_DEPTH + $urandom_range(1, 2) : $urandom_range(1, QUEUE_DEPTH);
        // An empty queue and ready map guarantee that the overfill reaches the limit.
        if (overfill) add_cmd(CMD_RESET, $urandom, $urandom, $urandom);
        for (i = 0; i < n; i++) begin
            t = $urandom_range(TAG_COUNT - 1);
            // Tags are mostly distinct; now and then one is queued more than once.
            while (used[t] && $urandom_range(19) != 0) t = $urandom_range(TAG_COUNT - 1);
            used[t] = 1'b1;
            order_tags.push_back(t);
        end
        abort_at = ($urandom_range(4) == 0) ? $urandom_range(1, 2 * n) : -1;
        sched = 0;
        steps = 0;
        while ((sched < n || open_tags.size() != 0) && steps != abort_at) begin
            roll = $urandom_range(99);
            steps++;
            if (overfill && sched < n) begin
                add_cmd(CMD_SCHEDULE, order_tags[sched], $urandom, $urandom);
                open_tags.push_back(order_tags[sched]);
                sched++;
            end else if (roll < 4) begin
                add_cmd($urandom_range(3), $urandom, $urandom, $urandom);
            end else if (roll < 8) begin
                add_cmd(CMD_FULFILL, $urandom, $urandom, $urandom);
            end else if (roll < 11) begin
                add_cmd(CMD_FLUSH, $urandom, $urandom, $urandom);
            end else if (sched < n && (open_tags.size() == 0 || roll < 55)) begin
                add_cmd(CMD_SCHEDULE, order_tags[sched], $urandom, $urandom);
                open_tags.push_back(order_tags[sched]);
                sched++;
            end else begin
                idx = $urandom_range(open_tags.size() - 1);
                add_cmd(CMD_FULFILL, open_tags[idx], $urandom, $urandom);
                // Leaving the tag open lets a later fulfill replace the frame.
                if ($urandom_range(9) != 0) open_tags.delete(idx);
            end
        end
        if (steps == abort_at) begin
            // Abandon the episode with a flush still waiting on the queue.
            add_cmd(CMD_FLUSH, $urandom, $urandom, $urandom);
            add_cmd(CMD_RESET, $urandom, $urandom, $urandom_range(255));
        end else begin
            roll = $urandom_range(99);
            if (roll < 45)
                add_cmd(CMD_FLUSH, $urandom, $urandom, $urandom);
            else if (roll < 60)
                add_cmd(CMD_RESET, $urandom, $urandom, $urandom_range(255));
        end
    endtask

    task automatic wait_sent();
        while (commands_to_send.size() != 0 || in_accepts != in_offers) @(posedge aclk);
    endtask

    // Test sequence: directed cases, then four handshake phases of random episodes.
    initial begin
        int phase;
        int target;
        @(posedge aresetn);

        // Reset with nothing pending, out-of-order fulfill and replacement.
        add_cmd(CMD_RESET, 0, 0, 8'hFF);
        add_cmd(CMD_SCHEDULE, 0, 0, 0);
        add_cmd(CMD_SCHEDULE, 63, 0, 0);
        add_cmd(CMD_FULFILL, 63, 32'hFFFF_FFFF, 0);
        add_cmd(CMD_FULFILL, 63, 32'h1234_5678, 0);
        add_cmd(CMD_FULFILL, 0, 32'h0000_0000, 0);
        // A tag fulfilled before it is scheduled is released when it is scheduled.
        add_cmd(CMD_FULFILL, 5, 32'hA5A5_A5A5, 0);
        add_cmd(CMD_SCHEDULE, 5, 0, 0);
        add_cmd(CMD_FLUSH, 0, 0, 0);
        // A flush that completes leaves a fulfilled but unscheduled tag in place.
        add_cmd(CMD_FULFILL, 7, 32'h5A5A_5A5A, 0);
        add_cmd(CMD_FLUSH, 0, 0, 0);
        add_cmd(CMD_SCHEDULE, 7, 0, 0);
        // Two flushes merge; the reset reports the waiting flush with its status.
        add_cmd(CMD_SCHEDULE, 1, 0, 0);
        add_cmd(CMD_FLUSH, 0, 0, 0);
        add_cmd(CMD_FLUSH, 0, 0, 0);
        add_cmd(CMD_RESET, 0, 0, 8'hFF);
        add_cmd(CMD_SCHEDULE, 2, 0, 0);
        add_cmd(CMD_FLUSH, 0, 0, 0);
        add_cmd(CMD_RESET, 0, 0, 8'h00);
        // A reset forgets fulfilled tags.
        add_cmd(CMD_FULFILL, 9, 32'hFFFF_FFFF, 0);
        add_cmd(CMD_RESET, 0, 0, 8'h3C);
        add_cmd(CMD_SCHEDULE, 9, 0, 0);
        add_cmd(CMD_FULFILL, 9, 32'h0000_FFFF, 0);
        add_cmd(CMD_FLUSH, 0, 0, 0);
        wait_sent();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    // Long output stall while commands keep coming.
                    hold_requests++;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase
            target = 24 + (phase + 1) * 112;
            add_episode(1'b1);
            while (commands_made < target) add_episode(1'b0);
            wait_sent();
            // After the second phase, let the buffer empty its output before the next phase starts.
            if (phase == 1)
                while (pending_releases.size() != 0) @(posedge aclk);
        end

        while (pending_releases.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d commands and %0d results: %0d frames, %0d flush-done, %0d overflow,",
                 in_accepts, results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("over four handshake phases and a %0d-cycle output stall.", HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
